// ===== rtl/core/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell word splitter package
// Shared types, character constants and result queue geometry for the shell word splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

  // One input transfer: a line byte or an end of line marker.
  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } sws_in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       word_end;
    logic       line_end;
    logic       run_last;
  } sws_out_t;

  // Lexer mode.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_SQ   = 2'd2,
    MODE_DQ   = 2'd3
  } sws_mode_e;

  // Character held back until the next byte decides its fate.
  typedef enum logic [1:0] {
    HOLD_NONE   = 2'd0,
    HOLD_DOLLAR = 2'd1,
    HOLD_BSLASH = 2'd2
  } sws_hold_e;

  // What the plain byte handling contributes to the result.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BYTE = 2'd1,
    ACT_WEND = 2'd2
  } sws_act_e;

  // Input kind codes.
  localparam logic KindByte = 1'b0;
  localparam logic KindEol  = 1'b1;

  // Characters of interest.
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreat  = 8'h3E;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Result queue geometry.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

endpackage

`default_nettype wire

// ===== rtl/core/shell_word_splitter.sv =====
// ----------------------------------------------------------------------------
// Shell word splitter
// Splits a streamed command line into words, removing quotes and escapes.
// ----------------------------------------------------------------------------
// Results are registered in the result queue before they reach the output.
// Input: one transfer per cycle while in_stall_o is low; an input yielding two
// results pushes both into the four-entry result queue.
// Reset: asynchronous, active low; clears the mode, the held character and
// the result queue.
`default_nettype none

module shell_word_splitter (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire sws_pkg::sws_in_t in_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output sws_pkg::sws_out_t out_o
);

  sws_pkg::sws_mode_e mode_q, mode_d, eff_mode, plain_mode;
  sws_pkg::sws_hold_e hold_q, hold_d, plain_hold;
  sws_pkg::sws_act_e  plain_act, act;

  logic [7:0] b;
  logic       in_fire, out_fire, is_digit;
  logic       pre_v;
  logic [7:0] pre_b;
  logic       use_plain;

  sws_pkg::sws_out_t res0, res1;
  logic [1:0]        push_n;

  sws_pkg::sws_out_t             fifo_q [sws_pkg::FifoDepth];
  logic [sws_pkg::PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [sws_pkg::CntW-1:0]      count_q;

  assign b        = in_i.in_byte;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign is_digit = (b >= sws_pkg::ChZero) && (b <= sws_pkg::ChNine);
  assign eff_mode = (mode_q == sws_pkg::MODE_IDLE) ? sws_pkg::MODE_WORD : mode_q;

  // Plain byte handling with nothing held.
  always_comb begin
    plain_mode = mode_q;
    plain_hold = sws_pkg::HOLD_NONE;
    plain_act  = sws_pkg::ACT_NONE;
    if (!(mode_q == sws_pkg::MODE_IDLE && b == sws_pkg::ChSpace)) begin
      plain_mode = eff_mode;
      if (b == sws_pkg::ChDollar) begin
        plain_hold = sws_pkg::HOLD_DOLLAR;
      end else begin
        unique case (eff_mode)
          sws_pkg::MODE_SQ: begin
            if (b == sws_pkg::ChSquote) plain_mode = sws_pkg::MODE_WORD;
            else plain_act = sws_pkg::ACT_BYTE;
          end
          sws_pkg::MODE_DQ: begin
            if (b == sws_pkg::ChDquote) plain_mode = sws_pkg::MODE_WORD;
            else if (b == sws_pkg::ChBslash) plain_hold = sws_pkg::HOLD_BSLASH;
            else plain_act = sws_pkg::ACT_BYTE;
          end
          default: begin
            if (b == sws_pkg::ChSpace) begin
              plain_act  = sws_pkg::ACT_WEND;
              plain_mode = sws_pkg::MODE_IDLE;
            end else if (b == sws_pkg::ChSquote) begin
              plain_mode = sws_pkg::MODE_SQ;
            end else if (b == sws_pkg::ChDquote) begin
              plain_mode = sws_pkg::MODE_DQ;
            end else if (b == sws_pkg::ChBslash) begin
              plain_hold = sws_pkg::HOLD_BSLASH;
            end else begin
              plain_act = sws_pkg::ACT_BYTE;
            end
          end
        endcase
      end
    end
  end

  // Decide the prefix byte and whether the plain handling applies.
  always_comb begin
    pre_v     = 1'b0;
    pre_b     = '0;
    use_plain = 1'b0;
    act       = sws_pkg::ACT_NONE;
    unique case (hold_q)
      sws_pkg::HOLD_DOLLAR: begin
        if (!is_digit) begin
          pre_v     = 1'b1;
          pre_b     = sws_pkg::ChDollar;
          use_plain = 1'b1;
        end
      end
      sws_pkg::HOLD_BSLASH: begin
        if (mode_q == sws_pkg::MODE_DQ) begin
          if (b == sws_pkg::ChBslash || b == sws_pkg::ChDquote || b == sws_pkg::ChDollar) begin
            act = sws_pkg::ACT_BYTE;
          end else begin
            pre_v     = 1'b1;
            pre_b     = sws_pkg::ChBslash;
            use_plain = 1'b1;
          end
        end else begin
          act = sws_pkg::ACT_BYTE;
          if (b == sws_pkg::ChLess || b == sws_pkg::ChGreat) begin
            pre_v = 1'b1;
            pre_b = sws_pkg::ChBslash;
          end
        end
      end
      default: begin
        use_plain = 1'b1;
      end
    endcase
    if (use_plain) act = plain_act;
  end

  // Assemble the results and the next state for this transfer.
  always_comb begin
    res0   = '0;
    res1   = '0;
    push_n = 2'd0;
    mode_d = use_plain ? plain_mode : mode_q;
    hold_d = use_plain ? plain_hold : sws_pkg::HOLD_NONE;
    if (in_i.kind == sws_pkg::KindEol) begin
      mode_d          = sws_pkg::MODE_IDLE;
      hold_d          = sws_pkg::HOLD_NONE;
      res0.line_end   = 1'b1;
      res0.run_last   = 1'b1;
      res0.word_end   = (mode_q != sws_pkg::MODE_IDLE);
      push_n          = 2'd1;
      if (hold_q == sws_pkg::HOLD_DOLLAR) begin
        res0.byte_valid = 1'b1;
        res0.out_byte   = sws_pkg::ChDollar;
      end else if (hold_q == sws_pkg::HOLD_BSLASH && mode_q == sws_pkg::MODE_DQ) begin
        res0.byte_valid = 1'b1;
        res0.out_byte   = sws_pkg::ChBslash;
      end
    end else if (pre_v) begin
      res0.byte_valid = 1'b1;
      res0.out_byte   = pre_b;
      if (act == sws_pkg::ACT_BYTE) begin
        res1.byte_valid = 1'b1;
        res1.out_byte   = b;
        res1.run_last   = 1'b1;
        push_n          = 2'd2;
      end else begin
        res0.word_end = (act == sws_pkg::ACT_WEND);
        res0.run_last = 1'b1;
        push_n        = 2'd1;
      end
    end else if (act == sws_pkg::ACT_BYTE) begin
      res0.byte_valid = 1'b1;
      res0.out_byte   = b;
      res0.run_last   = 1'b1;
      push_n          = 2'd1;
    end else if (act == sws_pkg::ACT_WEND) begin
      res0.word_end = 1'b1;
      res0.run_last = 1'b1;
      push_n        = 2'd1;
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sws_pkg::MODE_IDLE;
      hold_q <= sws_pkg::HOLD_NONE;
    end else if (in_fire) begin
      mode_q <= mode_d;
      hold_q <= hold_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (push_n != 2'd0) fifo_q[wr_ptr_q] <= res0;
      if (push_n == 2'd2) fifo_q[wr_ptr_q + sws_pkg::PtrW'(1)] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) wr_ptr_q <= wr_ptr_q + sws_pkg::PtrW'(push_n);
      if (out_fire) rd_ptr_q <= rd_ptr_q + sws_pkg::PtrW'(1);
      count_q <= count_q + (in_fire ? sws_pkg::CntW'(push_n) : '0)
                         - sws_pkg::CntW'(out_fire);
    end
  end

  // Accept only while two free slots remain for the worst case.
  assign in_stall_o  = (count_q > sws_pkg::CntW'(sws_pkg::FifoDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_o       = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire
